@@ rtl/uoi_pkg.sv @@
// package: types, constants and tables shared by the odometry integrator
package uoi_pkg;

  localparam int unsigned CORDIC_STEPS_DEF  = 16;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // shared multiplier
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 34;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam logic signed [MUL_B_W-1:0] YAW_K = MUL_B_W'(699971);

  // divide of the rounded distance product by one million through a reciprocal
  localparam int unsigned DIV_W  = 44;
  localparam int unsigned STEP_W = 5;
  localparam logic [DIV_W-1:0] DIST_HALF = DIV_W'(500000);
  localparam logic [DIV_W:0]   DIST_DIV  = (DIV_W+1)'(1000000);
  localparam logic [DIV_W:0]   DIST_DIV2 = (DIV_W+1)'(2000000);
  // floor(2^50 / 10^6), applied to the dividend bits above bit 19
  localparam logic signed [MUL_B_W-1:0] RECIP_K    = MUL_B_W'(64'sd1125899906);
  localparam logic signed [MUL_B_W-1:0] DIST_DIV_K = MUL_B_W'(1000000);

  // cordic
  localparam int unsigned CW = 33;
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);
  localparam logic signed [CW-1:0] QUARTER  = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF     = CW'(64'sd2147483648);

  localparam logic [29:0] ATAN_TABLE [32] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
    30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
    30'h00000001, 30'h00000000
  };

  localparam logic KIND_VEL  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [23:0] linear_velocity;
    logic signed [23:0] angular_velocity;
    logic        [19:0] elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [23:0] speed_echo;
    logic signed [23:0] turn_rate_echo;
  } out_item_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_VU, MUL_QE, MUL_QD, MUL_DC, MUL_DS, MUL_WU, MUL_KH, MUL_KL
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_VU, ST_DIVSET, ST_QEST, ST_QFIX, ST_ROT1SET, ST_ROT1, ST_DC, ST_XADD,
    ST_YADD, ST_KH, ST_KL, ST_YAW, ST_ROT2SET, ST_ROT2, ST_DONE
  } state_e;

  typedef struct packed {
    logic              load_speed;
    logic              load_tick;
    mul_sel_e          mul_sel;
    logic              div_set;
    logic              quo_save;
    logic              dist_load;
    logic              rot_set;
    logic              rot_half;
    logic              rot_step;
    logic              x_add;
    logic              y_add;
    logic              lo_save;
    logic              acc_load;
    logic              yaw_add;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/uoi_ctrl.sv @@
// controller: sequences one tick through the shared datapath
module uoi_ctrl #(
  parameter int unsigned CORDIC_STEPS = uoi_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_kind_i,
  output logic          in_stall_o,
  output uoi_pkg::cmd_t cmd_o,
  input  uoi_pkg::sts_t sts_i
);
  import uoi_pkg::*;

  localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);

  state_e state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.step = cnt_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_VEL) begin
            cmd_o.load_speed = 1'b1;
          end else begin
            cmd_o.load_tick = 1'b1;
            state_d = ST_VU;
          end
        end
      end
      ST_VU: begin
        cmd_o.mul_sel = MUL_VU;
        state_d = ST_DIVSET;
      end
      ST_DIVSET: begin
        cmd_o.div_set = 1'b1;
        state_d = ST_QEST;
      end
      ST_QEST: begin
        cmd_o.mul_sel = MUL_QE;
        state_d = ST_QFIX;
      end
      ST_QFIX: begin
        cmd_o.mul_sel = MUL_QD;
        cmd_o.quo_save = 1'b1;
        state_d = ST_ROT1SET;
      end
      ST_ROT1SET: begin
        cmd_o.dist_load = 1'b1;
        cmd_o.rot_set = 1'b1;
        cnt_d = '0;
        state_d = ST_ROT1;
      end
      ST_ROT1: begin
        cmd_o.rot_step = 1'b1;
        if (cnt_q == ROT_LAST) begin
          cnt_d = '0;
          state_d = ST_DC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DC: begin
        cmd_o.mul_sel = MUL_DC;
        state_d = ST_XADD;
      end
      ST_XADD: begin
        cmd_o.x_add = 1'b1;
        cmd_o.mul_sel = MUL_DS;
        state_d = ST_YADD;
      end
      ST_YADD: begin
        cmd_o.y_add = 1'b1;
        cmd_o.mul_sel = MUL_WU;
        state_d = ST_KH;
      end
      ST_KH: begin
        cmd_o.lo_save = 1'b1;
        cmd_o.mul_sel = MUL_KH;
        state_d = ST_KL;
      end
      ST_KL: begin
        cmd_o.acc_load = 1'b1;
        cmd_o.mul_sel = MUL_KL;
        state_d = ST_YAW;
      end
      ST_YAW: begin
        cmd_o.yaw_add = 1'b1;
        state_d = ST_ROT2SET;
      end
      ST_ROT2SET: begin
        cmd_o.rot_set = 1'b1;
        cmd_o.rot_half = 1'b1;
        state_d = ST_ROT2;
      end
      ST_ROT2: begin
        cmd_o.rot_step = 1'b1;
        if (cnt_q == ROT_LAST) begin
          cnt_d = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/uoi_datapath.sv @@
// datapath: pose state, shared multiplier, reciprocal divide, cordic and output register
module uoi_datapath #(
  parameter int unsigned POSITION_BITS = uoi_pkg::POSITION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  uoi_pkg::in_item_t  in_item_i,
  input  uoi_pkg::cmd_t      cmd_i,
  output uoi_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uoi_pkg::out_item_t out_item_o
);
  import uoi_pkg::*;

  localparam int unsigned SUM_W = (POSITION_BITS > 32 ? POSITION_BITS : 32) + 2;
  localparam logic signed [SUM_W-1:0] PMAX = SUM_W'({1'b0, {(POSITION_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] PMIN = ~PMAX;
  localparam logic signed [SUM_W-1:0] I32MAX = SUM_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] I32MIN = ~I32MAX;

  // pose state
  logic signed [POSITION_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [31:0] yaw_q, yaw_d;
  logic signed [23:0] speed_q, speed_d, turn_q, turn_d;
  logic out_valid_q, out_valid_d;

  // working registers
  logic [19:0] us_q, us_d;
  logic signed [MUL_P_W-1:0] prod_q, prod_d, acc_q, acc_d;
  logic [DIV_W-1:0] dq_q, dq_d;
  logic [23:0] quo_q, quo_d;
  logic neg_q, neg_d, flip_q, flip_d;
  logic signed [MUL_A_W-1:0] dist_q, dist_d;
  logic [22:0] lo_q, lo_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d, ca_q, ca_d;
  out_item_t out_q, out_d;

  function automatic logic signed [POSITION_BITS-1:0] sat_pos(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] r;
    r = (v > PMAX) ? PMAX : ((v < PMIN) ? PMIN : v);
    return r[POSITION_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [POSITION_BITS-1:0] v);
    logic signed [SUM_W-1:0] e, r;
    e = SUM_W'(v);
    r = (e > I32MAX) ? I32MAX : ((e < I32MIN) ? I32MIN : e);
    return r[31:0];
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t, s;
    t = v + CW'(16384);
    s = t >>> 15;
    if (s > CW'(32767)) return 16'sh7FFF;
    else if (s < -CW'(32768)) return 16'sh8000;
    else return s[15:0];
  endfunction

  logic signed [MUL_A_W-1:0] ma;
  logic signed [MUL_B_W-1:0] mb;
  logic signed [MUL_P_W-1:0] mp, rnd, yaw_sum;
  logic signed [CW-1:0] cos_v, sin_v, xs, ys, at, a0;
  logic signed [MUL_P_W-1:0] abs_p;
  logic [DIV_W:0] rdiff;
  logic [23:0] quo_fix;
  logic [31:0] ang;
  logic signed [28:0] dx;
  logic signed [SUM_W-1:0] psum;
  logic [4:0] idx;

  assign cos_v = flip_q ? -cx_q : cx_q;
  assign sin_v = flip_q ? -cy_q : cy_q;
  assign idx   = cmd_i.step[4:0];

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_VU: begin ma = MUL_A_W'(speed_q); mb = MUL_B_W'({1'b0, us_q}); end
      MUL_QE: begin ma = MUL_A_W'({1'b0, dq_q[DIV_W-1:20]}); mb = RECIP_K; end
      MUL_QD: begin ma = MUL_A_W'({1'b0, prod_q[53:30]}); mb = DIST_DIV_K; end
      MUL_DC: begin ma = dist_q; mb = MUL_B_W'(cos_v); end
      MUL_DS: begin ma = dist_q; mb = MUL_B_W'(sin_v); end
      MUL_WU: begin ma = MUL_A_W'(turn_q); mb = MUL_B_W'({1'b0, us_q}); end
      MUL_KH: begin ma = prod_q[47:23]; mb = YAW_K; end
      MUL_KL: begin ma = MUL_A_W'({1'b0, lo_q}); mb = YAW_K; end
      default: begin ma = '0; mb = '0; end
    endcase
    mp = MUL_P_W'(ma) * MUL_P_W'(mb);
  end

  always_comb begin
    speed_d     = speed_q;
    turn_d      = turn_q;
    us_d        = us_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    yaw_d       = yaw_q;
    prod_d      = (cmd_i.mul_sel != MUL_NONE) ? mp : prod_q;
    acc_d       = acc_q;
    dq_d        = dq_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    dist_d      = dist_q;
    lo_d        = lo_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    ca_d        = ca_q;
    flip_d      = flip_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.load_speed) begin
      speed_d = in_item_i.linear_velocity;
      turn_d  = in_item_i.angular_velocity;
    end
    if (cmd_i.load_tick) us_d = in_item_i.elapsed_us;

    // rounded magnitude, quotient estimate from the top bits, then a remainder fix
    abs_p = prod_q[MUL_P_W-1] ? -prod_q : prod_q;
    if (cmd_i.div_set) begin
      dq_d  = abs_p[DIV_W-1:0] + DIST_HALF;
      neg_d = prod_q[MUL_P_W-1];
    end
    if (cmd_i.quo_save) quo_d = prod_q[53:30];
    // the estimate is low by at most two
    rdiff   = {1'b0, dq_q} - prod_q[DIV_W:0];
    quo_fix = (rdiff >= DIST_DIV2) ? quo_q + 24'd2 :
              ((rdiff >= DIST_DIV) ? quo_q + 24'd1 : quo_q);
    if (cmd_i.dist_load) begin
      dist_d = neg_q ? -MUL_A_W'({1'b0, quo_fix}) : MUL_A_W'({1'b0, quo_fix});
    end

    // cordic setup with quadrant fold
    ang = cmd_i.rot_half ? {1'b0, yaw_q[31:1]} : yaw_q;
    a0  = CW'(signed'(ang));
    if (cmd_i.rot_set) begin
      cx_d = GAIN_Q30;
      cy_d = '0;
      if (a0 > QUARTER) begin
        ca_d = a0 - HALF;
        flip_d = 1'b1;
      end else if (a0 < -QUARTER) begin
        ca_d = a0 + HALF;
        flip_d = 1'b1;
      end else begin
        ca_d = a0;
        flip_d = 1'b0;
      end
    end
    xs = cx_q >>> idx;
    ys = cy_q >>> idx;
    at = CW'({1'b0, ATAN_TABLE[idx]});
    if (cmd_i.rot_step) begin
      if (!ca_q[CW-1]) begin
        cx_d = cx_q - ys;
        cy_d = cy_q + xs;
        ca_d = ca_q - at;
      end else begin
        cx_d = cx_q + ys;
        cy_d = cy_q - xs;
        ca_d = ca_q + at;
      end
    end

    // position update from the registered product
    rnd  = prod_q + MUL_P_W'(64'sd536870912);
    dx   = rnd[MUL_P_W-1:30];
    psum = SUM_W'(cmd_i.y_add ? pos_y_q : pos_x_q) + SUM_W'(dx);
    if (cmd_i.x_add) pos_x_d = sat_pos(psum);
    if (cmd_i.y_add) pos_y_d = sat_pos(psum);

    // heading: high and low partial products of w*us*k
    if (cmd_i.lo_save) lo_d = prod_q[22:0];
    if (cmd_i.acc_load) acc_d = prod_q;
    yaw_sum = (acc_q <<< 23) + prod_q + MUL_P_W'(64'sd33554432);
    if (cmd_i.yaw_add) yaw_d = yaw_q + yaw_sum[57:26];

    if (cmd_i.out_load) begin
      out_d.pos_x          = sat32(pos_x_q);
      out_d.pos_y          = sat32(pos_y_q);
      out_d.heading        = yaw_q;
      out_d.quat_z         = to_q15(sin_v);
      out_d.quat_w         = to_q15(cos_v);
      out_d.speed_echo     = speed_q;
      out_d.turn_rate_echo = turn_q;
      out_valid_d          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      yaw_q       <= '0;
      speed_q     <= '0;
      turn_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      yaw_q       <= yaw_d;
      speed_q     <= speed_d;
      turn_q      <= turn_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    us_q   <= us_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    dq_q   <= dq_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    dist_q <= dist_d;
    lo_q   <= lo_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    ca_q   <= ca_d;
    flip_q <= flip_d;
    out_q  <= out_d;
  end

  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_q;

endmodule

@@ rtl/unicycle_odometry_integrator_core.sv @@
// top level: dead-reckoning unicycle odometry integrator
// A velocity command item only updates the held speed and yaw rate; it gives no
// result. A tick item runs through a controller and one shared datapath: v*us on a
// single 25x34 multiplier, a divide by one million done as a reciprocal multiply
// followed by a multiply-back remainder fix (with the sign and rounding setup), a
// CORDIC of the old heading, the x and y updates and the heading step, then a CORDIC
// of the half heading for the yaw quaternion. The input is free again on the cycle
// after the result is loaded. The result sits in an output register, so a finished
// result may wait under stall while the next item is accepted; a further tick only
// waits at its own end if the previous result has not been taken.
// positions are Q16.16 saturating at POSITION_BITS and reported saturated to 32 bits;
// heading is a wrapping 32-bit binary angle
module unicycle_odometry_integrator_core #(
  parameter int unsigned CORDIC_STEPS  = uoi_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned POSITION_BITS = uoi_pkg::POSITION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  uoi_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output uoi_pkg::out_item_t out_item_o
);
  import uoi_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer for one tick item
  uoi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_kind_i (in_item_i.kind),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // pose state, arithmetic and the output register
  uoi_datapath #(
    .POSITION_BITS(POSITION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ rtl/uoi_checker.sv @@
// checker: port-level properties of the odometry integrator, bound to the top level
module uoi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input uoi_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input uoi_pkg::out_item_t out_item_o
);
  import uoi_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // a tick keeps the block busy on the following cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == KIND_TICK |=> in_stall_o)
    else $error("input not stalled after a tick");

  // a result never appears right after a tick is taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == KIND_TICK |=> !$rose(out_valid_o))
    else $error("result too early after a tick");

  // a velocity command leaves the block free for the next item
  a_cmd_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == KIND_VEL |=> !in_stall_o)
    else $error("busy after a velocity command");

endmodule

bind unicycle_odometry_integrator_core uoi_checker u_chk (.*);
